// ===== design/assert_macros.svh =====
// assertion macros shared by the timer task queue rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define TTQ_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("implication check failed");

// next-cycle implication, disabled during reset
`define TTQ_ASSERT_NXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle check failed");

`endif

// ===== design/ttq_pkg.sv =====
// types, codes and sizes for the timer task queue
// no dependencies
package ttq_pkg;

  localparam int TASK_SLOTS = 16;
  localparam int IDX_W      = $clog2(TASK_SLOTS);

  typedef enum logic [2:0] {
    CMD_ADD    = 3'd0,
    CMD_REMOVE = 3'd1,
    CMD_RESCHED = 3'd2,
    CMD_TICK   = 3'd3,
    CMD_CLEAR  = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    ST_ADDED    = 3'd0,
    ST_FULL     = 3'd1,
    ST_FIRED    = 3'd2,
    ST_TICKDONE = 3'd3,
    ST_REMOVED  = 3'd4,
    ST_NOTFOUND = 3'd5,
    ST_RESCHED  = 3'd6
  } status_e;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_APPLY
  } fsm_e;

  // one task entry as held in a cell
  typedef struct packed {
    logic        valid;
    logic [31:0] id;
    logic [31:0] expiry;
    logic [23:0] delay;
    logic        periodic;
    logic [31:0] stamp;
  } entry_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift;
    logic clear;
  } cell_ctrl_t;

endpackage

// ===== design/ttq_cell.sv =====
// one task slot of the rotating ring
// depends on ttq_pkg
module ttq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  ttq_pkg::cell_ctrl_t ctrl_i,
  input  ttq_pkg::entry_t     shift_in_i,
  input  logic                wr_en_i,
  input  ttq_pkg::entry_t     wr_data_i,
  output ttq_pkg::entry_t     entry_o
);
  import ttq_pkg::*;

  logic   valid_q;
  entry_t data_q;

  // valid bit, cleared by reset and clear all
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ctrl_i.clear) begin
      valid_q <= 1'b0;
    end else if (wr_en_i) begin
      valid_q <= wr_data_i.valid;
    end else if (ctrl_i.shift) begin
      valid_q <= shift_in_i.valid;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      data_q <= wr_data_i;
    end else if (ctrl_i.shift) begin
      data_q <= shift_in_i;
    end
  end

  always_comb begin
    entry_o       = data_q;
    entry_o.valid = valid_q;
  end

endmodule

// ===== design/timer_task_queue_unit.sv =====
// Timer task queue: a ring of TASK_SLOTS cells rotates past one head comparator.
// Each search rotates the whole ring past the head in FSM_SCAN, then writes back in FSM_APPLY.
// Add, remove, reschedule: one search. Tick: one search per fired task plus a final one.
// Clear and unused codes complete in the idle state; otherwise the next command is accepted
// once the final word is registered. One command at a time.
// Reset (async, active low) empties the table and zeroes time, id and stamp counters.
module timer_task_queue_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [2:0]  cmd_i,
  input  logic [31:0] task_id_i,
  input  logic [23:0] delay_ticks_i,
  input  logic        periodic_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [2:0]  status_o,
  output logic [31:0] result_id_o,
  output logic        last_o
);
  import ttq_pkg::*;
  `include "assert_macros.svh"

  fsm_e state_q, state_d;
  logic [IDX_W-1:0] cnt_q, cnt_d;
  logic [2:0]  cmd_q;
  logic [31:0] tid_q;
  logic [23:0] dly_q;
  logic        per_q;
  logic [31:0] time_q, time_d, nid_q, nid_d, stamp_q, stamp_d;

  // best candidate of the current search
  logic             found_q, found_d;
  logic [IDX_W-1:0] bidx_q, bidx_d;
  logic [31:0]      bkey_q, bkey_d, bstamp_q, bstamp_d, bid_q, bid_d;
  logic [23:0]      bdly_q, bdly_d;
  logic             bper_q, bper_d;

  // output register
  logic        ovalid_q, ovalid_d;
  logic [2:0]  ostat_q, ostat_d;
  logic [31:0] oid_q, oid_d;
  logic        olast_q, olast_d;

  entry_t          ent [TASK_SLOTS];
  logic            wr_en [TASK_SLOTS];
  entry_t          wr_data;
  logic            wr_any;
  cell_ctrl_t      cctl;

  // ring of cells, cell 0 is the head
  for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
    ttq_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (cctl),
      .shift_in_i (ent[(g + 1) % TASK_SLOTS]),
      .wr_en_i    (wr_en[g]),
      .wr_data_i  (wr_data),
      .entry_o    (ent[g])
    );
  end

  always_comb begin
    for (int i = 0; i < TASK_SLOTS; i++) begin
      wr_en[i] = wr_any && (bidx_q == IDX_W'(i));
    end
  end

  // head comparator
  entry_t      head;
  logic [31:0] hkey;
  logic        hbefore, hdue, hcand;
  always_comb begin
    head    = ent[0];
    hkey    = (time_q - head.expiry) ^ 32'h8000_0000;
    hdue    = hkey[31];
    hbefore = (hkey > bkey_q) ||
              ((hkey == bkey_q) && ((head.stamp - bstamp_q) >= 32'h8000_0000));
    hcand   = 1'b0;
    unique case (cmd_q)
      CMD_ADD:                hcand = !head.valid && !found_q;
      CMD_REMOVE, CMD_RESCHED: hcand = head.valid && (head.id == tid_q) &&
                                       (!found_q || hbefore);
      CMD_TICK:               hcand = head.valid && hdue && (!found_q || hbefore);
      default:                hcand = 1'b0;
    endcase
  end

  logic in_acc, out_free;
  assign in_acc   = in_valid_i && in_ready_o;
  assign out_free = !ovalid_q || out_ready_i;

  // sequencer
  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    time_d   = time_q;
    nid_d    = nid_q;
    stamp_d  = stamp_q;
    found_d  = found_q;
    bidx_d   = bidx_q;
    bkey_d   = bkey_q;
    bstamp_d = bstamp_q;
    bid_d    = bid_q;
    bdly_d   = bdly_q;
    bper_d   = bper_q;
    ovalid_d = ovalid_q && !out_ready_i;
    ostat_d  = ostat_q;
    oid_d    = oid_q;
    olast_d  = olast_q;
    cctl     = '0;
    wr_any   = 1'b0;
    wr_data  = head;
    in_ready_o = 1'b0;
    unique case (state_q)
      FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          found_d = 1'b0;
          cnt_d   = '0;
          if (cmd_i == CMD_CLEAR) begin
            cctl.clear = 1'b1;
          end else if (cmd_i <= CMD_TICK) begin
            state_d = FSM_SCAN;
            if (cmd_i == CMD_TICK) time_d = time_q + 32'd1;
          end
        end
      end
      FSM_SCAN: begin
        cctl.shift = 1'b1;
        if (hcand) begin
          found_d  = 1'b1;
          bidx_d   = cnt_q;
          bkey_d   = hkey;
          bstamp_d = head.stamp;
          bid_d    = head.id;
          bdly_d   = head.delay;
          bper_d   = head.periodic;
        end
        cnt_d = cnt_q + IDX_W'(1);
        if (cnt_q == IDX_W'(TASK_SLOTS - 1)) state_d = FSM_APPLY;
      end
      FSM_APPLY: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          olast_d  = 1'b1;
          oid_d    = tid_q;
          state_d  = FSM_IDLE;
          wr_data.valid    = 1'b1;
          wr_data.id       = bid_q;
          wr_data.expiry   = time_q + {8'd0, dly_q};
          wr_data.delay    = dly_q;
          wr_data.periodic = bper_q;
          wr_data.stamp    = stamp_q;
          unique case (cmd_q)
            CMD_ADD: begin
              if (found_q) begin
                wr_any           = 1'b1;
                wr_data.id       = nid_q + 32'd1;
                wr_data.periodic = per_q;
                nid_d   = nid_q + 32'd1;
                stamp_d = stamp_q + 32'd1;
                ostat_d = ST_ADDED;
                oid_d   = nid_q + 32'd1;
              end else begin
                ostat_d = ST_FULL;
                oid_d   = '0;
              end
            end
            CMD_REMOVE: begin
              if (found_q) begin
                wr_any        = 1'b1;
                wr_data.valid = 1'b0;
                ostat_d       = ST_REMOVED;
              end else begin
                ostat_d = ST_NOTFOUND;
              end
            end
            CMD_RESCHED: begin
              if (found_q) begin
                wr_any  = 1'b1;
                stamp_d = stamp_q + 32'd1;
                ostat_d = ST_RESCHED;
              end else begin
                ostat_d = ST_NOTFOUND;
              end
            end
            default: begin
              if (found_q) begin
                // fire, re-arm or drop, then search again
                wr_any        = 1'b1;
                wr_data.delay = bdly_q;
                wr_data.valid = bper_q;
                wr_data.expiry = time_q + ((bdly_q == 24'd0) ? 32'd1 : {8'd0, bdly_q});
                if (bper_q) stamp_d = stamp_q + 32'd1;
                ostat_d = ST_FIRED;
                oid_d   = bid_q;
                olast_d = 1'b0;
                found_d = 1'b0;
                cnt_d   = '0;
                state_d = FSM_SCAN;
              end else begin
                ostat_d = ST_TICKDONE;
                oid_d   = '0;
              end
            end
          endcase
        end
      end
      default: state_d = FSM_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= FSM_IDLE;
      cnt_q    <= '0;
      time_q   <= '0;
      nid_q    <= '0;
      stamp_q  <= '0;
      found_q  <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      time_q   <= time_d;
      nid_q    <= nid_d;
      stamp_q  <= stamp_d;
      found_q  <= found_d;
      ovalid_q <= ovalid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q <= cmd_i;
      tid_q <= task_id_i;
      dly_q <= delay_ticks_i;
      per_q <= periodic_i;
    end
    bidx_q   <= bidx_d;
    bkey_q   <= bkey_d;
    bstamp_q <= bstamp_d;
    bid_q    <= bid_d;
    bdly_q   <= bdly_d;
    bper_q   <= bper_d;
    ostat_q  <= ostat_d;
    oid_q    <= oid_d;
    olast_q  <= olast_d;
  end

  assign out_valid_o = ovalid_q;
  assign status_o    = ostat_q;
  assign result_id_o = oid_q;
  assign last_o      = olast_q;

  // ring must be back in home position when results are applied
  `TTQ_ASSERT_IMP(a_ring_home, clk_i, rst_ni, state_q == FSM_APPLY, cnt_q == '0)
  // a fired word is never the final one
  `TTQ_ASSERT_IMP(a_fired_not_last, clk_i, rst_ni,
                  ovalid_q && (ostat_q == ST_FIRED), !olast_q)
  // a tick advances time by exactly one
  `TTQ_ASSERT_NXT(a_tick_time, clk_i, rst_ni, in_acc && (cmd_i == CMD_TICK),
                  time_q == $past(time_q) + 32'd1)

endmodule
